>>> rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, switched off while reset is high
`define WTK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// concurrent assertion checked during reset as well
`define WTK_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/wtk_pkg.sv
// package with the shared types and constants of the word tokenizer hasher
`default_nettype none

package wtk_pkg;

   // fnv-1a 32-bit constants
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   // fixed line-end bytes
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // upper case range folded to lower case
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT     = 8'h20;

   // delimiter register
   localparam int          DELIM_SLOTS = 8;
   localparam logic [63:0] DELIM_RESET = 64'h0A3A3B3F212E2C20;

   // parameter defaults
   localparam int TABLE_SIZE_DEFAULT = 16384;
   localparam int WORD_LIMIT_DEFAULT = 100;

   // one input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

endpackage

`default_nettype wire

>>> rtl/word_tokenizer_fnv1a_hasher_unit.sv
// top level of the word tokenizer with fnv-1a hashing
//
//   channel  ports             direction  payload
//   req      req_valid/stall   in         data_byte, last_byte
//   rsp      rsp_valid/stall   out        word_hash, bucket_index, hashed_length
//   csr      csr_write_*       in         delimiter_list (64 bits, write only)
//
// one byte per cycle unless a held result is stalled; a result becomes valid after its closing byte is accepted
// (the byte waits in the input register, then the hash round loads the result register)
// the hash round against the word state is the loop that sets the rate
// synchronous active-high reset clears the word state and loads the default delimiters
// a stalled result holds its register; the input register still takes one more byte
`default_nettype none

`include "assert_macros.svh"

module word_tokenizer_fnv1a_hasher_unit
   import wtk_pkg::*;
#(
   parameter  int TABLE_SIZE = TABLE_SIZE_DEFAULT,
   parameter  int WORD_LIMIT = WORD_LIMIT_DEFAULT,
   localparam int BUCKET_W   = $clog2(TABLE_SIZE),
   localparam int LEN_W      = $clog2(WORD_LIMIT)
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_word_hash,
   output logic [BUCKET_W-1:0] rsp_bucket_index,
   output logic [LEN_W-1:0]    rsp_hashed_length,
   input  logic                csr_write_enable,
   input  logic [63:0]         csr_write_data
);

   logic [63:0]         delim_ff;
   logic                in_valid_ff;
   item_type            in_item_ff;
   logic                rsp_valid_ff;
   logic [31:0]         rsp_hash_ff;
   logic [LEN_W-1:0]    rsp_len_ff;
   logic                advance, step, take, is_sep, emit;
   logic [31:0]         eng_hash;
   logic [LEN_W-1:0]    eng_len;

   // pipeline moves unless a held result is stalled
   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign step      = advance && in_valid_ff;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // delimiter register
   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
      end else if (csr_write_enable) begin
         delim_ff <= csr_write_data;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance || !in_valid_ff) begin
         in_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= '{data_byte: req_data_byte, last_byte: req_last_byte};
      end
   end

   wtk_delim_match u_delim (
      .delimiter_list (delim_ff),
      .data_byte      (in_item_ff.data_byte),
      .is_sep         (is_sep)
   );

   wtk_word_engine #(
      .WORD_LIMIT (WORD_LIMIT)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (in_item_ff),
      .is_sep        (is_sep),
      .emit          (emit),
      .word_hash     (eng_hash),
      .hashed_length (eng_len)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_hash_ff <= eng_hash;
         rsp_len_ff  <= eng_len;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word_hash     = rsp_hash_ff;
   assign rsp_bucket_index  = rsp_hash_ff[BUCKET_W-1:0];
   assign rsp_hashed_length = rsp_len_ff;

   `WTK_ASSERT(a_len_in_range, clock, reset,
      rsp_valid_ff |-> (rsp_len_ff <= LEN_W'(WORD_LIMIT - 1)), "result length out of range")
   `WTK_ASSERT(a_stall_needs_item, clock, reset,
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=> in_valid_ff, "queued byte dropped")
   `WTK_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_hash_ff)),
      "stalled result changed")

endmodule

`default_nettype wire

>>> rtl/wtk_delim_match.sv
// separator detection against line ends and the delimiter list
`default_nettype none

module wtk_delim_match
   import wtk_pkg::*;
(
   input  logic [63:0] delimiter_list,
   input  logic [7:0]  data_byte,
   output logic        is_sep
);

   logic [DELIM_SLOTS-1:0] slot_hit;
   logic [DELIM_SLOTS-1:0] slot_live;

   // a slot counts only while no earlier slot held a zero byte
   always_comb begin
      slot_live[0] = 1'b1;
      for (int i = 1; i < DELIM_SLOTS; i++) begin
         slot_live[i] = slot_live[i-1] && (delimiter_list[8*(i-1) +: 8] != 8'h00);
      end
   end

   // per-slot compare, zero terminates the list
   always_comb begin
      for (int i = 0; i < DELIM_SLOTS; i++) begin
         slot_hit[i] = slot_live[i] && (delimiter_list[8*i +: 8] != 8'h00)
                       && (delimiter_list[8*i +: 8] == data_byte);
      end
   end

   assign is_sep = (data_byte == CHAR_LF) || (data_byte == CHAR_CR) || (|slot_hit);

endmodule

`default_nettype wire

>>> rtl/wtk_word_engine.sv
// word state and fnv-1a hash update, one byte per step
`default_nettype none

`include "assert_macros.svh"

module wtk_word_engine
   import wtk_pkg::*;
#(
   parameter  int WORD_LIMIT = WORD_LIMIT_DEFAULT,
   localparam int LEN_W      = $clog2(WORD_LIMIT)
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  item_type         item,
   input  logic             is_sep,
   output logic             emit,
   output logic [31:0]      word_hash,
   output logic [LEN_W-1:0] hashed_length
);

   localparam logic [LEN_W-1:0] KEEP_MAX = LEN_W'(WORD_LIMIT - 1);

   logic [31:0]      hash_ff, hash_in, hash_nx, hash_mix;
   logic [LEN_W-1:0] slen_ff, slen_in, slen_nx;
   logic [LEN_W-1:0] hcnt_ff, hcnt_in, hcnt_nx;
   logic             zs_ff, zs_in, zs_nx;
   logic             keep, upd, clear;
   logic [7:0]       folded;

   // lower-case fold of A..Z only
   always_comb begin
      if (item.data_byte >= CHAR_UPPER_A && item.data_byte <= CHAR_UPPER_Z) begin
         folded = item.data_byte | CASE_BIT;
      end else begin
         folded = item.data_byte;
      end
   end

   // one fnv-1a round, xor then constant multiply
   assign hash_mix = 32'((hash_ff ^ {24'h000000, folded}) * FNV_PRIME);

   // byte bookkeeping for the running word
   always_comb begin
      keep    = !is_sep && (slen_ff < KEEP_MAX);
      zs_nx   = zs_ff || (keep && (item.data_byte == 8'h00));
      upd     = keep && !zs_nx;
      slen_nx = keep ? slen_ff + 1'b1 : slen_ff;
      hcnt_nx = upd ? hcnt_ff + 1'b1 : hcnt_ff;
      hash_nx = upd ? hash_mix : hash_ff;
   end

   // word ends on a separator or at the stream end, only when nonempty
   assign emit          = (slen_nx != '0) && (is_sep || item.last_byte);
   assign clear         = emit || item.last_byte;
   assign word_hash     = hash_nx;
   assign hashed_length = hcnt_nx;

   // next state, back to the basis after a word or the last byte
   always_comb begin
      if (clear) begin
         hash_in = FNV_BASIS;
         slen_in = '0;
         hcnt_in = '0;
         zs_in   = 1'b0;
      end else begin
         hash_in = hash_nx;
         slen_in = slen_nx;
         hcnt_in = hcnt_nx;
         zs_in   = zs_nx;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         slen_ff <= '0;
         hcnt_ff <= '0;
         zs_ff   <= 1'b0;
      end else if (step) begin
         hash_ff <= hash_in;
         slen_ff <= slen_in;
         hcnt_ff <= hcnt_in;
         zs_ff   <= zs_in;
      end
   end

   `WTK_ASSERT(a_hcnt_le_slen, clock, reset, hcnt_ff <= slen_ff, "hashed count above word length")
   `WTK_ASSERT(a_zero_nonempty, clock, reset, !zs_ff || (slen_ff != '0), "zero flag on empty word")
   `WTK_ASSERT(a_last_clears, clock, reset,
      (step && item.last_byte) |=> ((slen_ff == '0) && (hash_ff == FNV_BASIS)),
      "state not cleared after last byte")

endmodule

`default_nettype wire
